// File: design/sfd_pkg.sv
// Shared types and constants for the sync/length frame deframer with Fletcher checks.
`default_nettype none
package sfd_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int CODE_W = 3;
  localparam int POS_W = WORD_W + 1;
  localparam int COUNTER_WIDTH = 16;

  // APB register map: one 32-bit register every four bytes.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SYNC_FIRST = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET = 8'hBE;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'hEF;

  typedef enum logic [CODE_W-1:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_TYPE  = 3'd2,
    PH_LEN   = 3'd3,
    PH_HCHK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  typedef enum logic [CODE_W-1:0] {
    EV_NONE    = 3'd0,
    EV_SYNC    = 3'd1,
    EV_HDR_BAD = 3'd2,
    EV_PAY_BAD = 3'd3,
    EV_GOOD    = 3'd4
  } event_t;

endpackage
`default_nettype wire

// File: design/sfd_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
`default_nettype none
interface sfd_in_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  import sfd_pkg::*;
  logic              valid;
  logic              ready;
  logic              payload_valid;
  logic [BYTE_W-1:0] payload_byte;
  logic [WORD_W-1:0] payload_offset;
  logic [BYTE_W-1:0] frame_type;
  logic [WORD_W-1:0] frame_length;
  logic [CODE_W-1:0] event_code;
  logic [WORD_W-1:0] sync_error_count;
  logic [WORD_W-1:0] checksum_error_count;
  logic [WORD_W-1:0] good_frame_count;
  logic [CODE_W-1:0] parser_phase;

  modport source (
    output valid, input ready,
    output payload_valid, output payload_byte, output payload_offset,
    output frame_type, output frame_length, output event_code,
    output sync_error_count, output checksum_error_count,
    output good_frame_count, output parser_phase
  );
  modport sink (
    input valid, output ready,
    input payload_valid, input payload_byte, input payload_offset,
    input frame_type, input frame_length, input event_code,
    input sync_error_count, input checksum_error_count,
    input good_frame_count, input parser_phase
  );
endinterface
`default_nettype wire

// File: design/sync_frame_deframer_fletcher_unit.sv
// Top level: byte-serial frame parser with Fletcher-style header and payload checks.
//
//   channel   direction  carries
//   in_ch     sink       rx_byte, one received byte per request
//   out_ch    source     one parser result per byte (payload, header, event, counters)
//   apb       slave      sync_first at 0x0, sync_second at 0x4
//
// A byte's result reaches the result register by way of the input register: the byte
// sits in the input register while the parser logic works on it, and the result register
// loads the result when it can advance. One byte per cycle is sustained while results are
// taken; the limit is the single parser state update per byte.
// Reset (rst, synchronous) returns the parser to hunting for the first sync byte,
// clears the counters and loads the default sync values.
// A stalled result register holds the parser stage, and input ready drops only when
// both stages are full and the result is not being taken.
`default_nettype none
module sync_frame_deframer_fletcher_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  sfd_in_if.sink                               in_ch,
  sfd_out_if.source                            out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sfd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [sfd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [sfd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import sfd_pkg::*;

  logic [BYTE_W-1:0] sync_first;
  logic [BYTE_W-1:0] sync_second;

  // Input register stage.
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_adv;
  logic              s1_fire;

  // Parser state.
  phase_t                   phase, phase_next;
  logic [POS_W-1:0]         position, position_next;
  logic [BYTE_W-1:0]        type_reg, type_reg_next;
  logic [WORD_W-1:0]        length_reg, length_reg_next;
  logic [BYTE_W-1:0]        sum_first, sum_first_next;
  logic [BYTE_W-1:0]        sum_second, sum_second_next;
  logic [BYTE_W-1:0]        held_check_byte, held_check_byte_next;
  logic [COUNTER_WIDTH-1:0] sync_errors, sync_errors_next;
  logic [COUNTER_WIDTH-1:0] check_errors, check_errors_next;
  logic [COUNTER_WIDTH-1:0] good_frames, good_frames_next;

  logic [BYTE_W-1:0] sf_add;
  logic [BYTE_W-1:0] ss_add;
  logic              pos_zero;
  logic              in_payload;
  logic              at_check_low;
  logic              check_ok;
  logic              sync1_ok;
  logic              sync2_ok;

  logic              pv;
  logic [BYTE_W-1:0] pb;
  logic [WORD_W-1:0] poff;
  event_t            ev;

  logic              out_valid;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_SYNC_FIRST) begin
        sync_first <= pwdata[BYTE_W-1:0];
      end else begin
        sync_second <= pwdata[BYTE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SYNC_FIRST) begin
      prdata[BYTE_W-1:0] = sync_first;
    end else begin
      prdata[BYTE_W-1:0] = sync_second;
    end
  end

  // ---------------- handshake ----------------
  assign s1_adv      = !out_valid || out_ch.ready;
  assign s1_fire     = s1_valid && s1_adv;
  assign in_ch.ready = !s1_valid || s1_adv;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.rx_byte;
    end
  end

  // ---------------- shared decode ----------------
  assign sf_add       = sum_first + s1_byte;
  assign ss_add       = sum_second + sf_add;
  assign pos_zero     = (position == '0);
  assign in_payload   = (position < {1'b0, length_reg});
  assign at_check_low = (position == {1'b0, length_reg});
  assign check_ok     = (held_check_byte == sum_first) && (s1_byte == sum_second);
  assign sync1_ok     = (s1_byte == sync_first);
  assign sync2_ok     = (s1_byte == sync_second);

  // ---------------- next phase ----------------
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SYNC1: if (sync1_ok) phase_next = PH_SYNC2;
      PH_SYNC2: phase_next = sync2_ok ? PH_TYPE : PH_SYNC1;
      PH_TYPE:  phase_next = PH_LEN;
      PH_LEN:   if (!pos_zero) phase_next = PH_HCHK;
      PH_HCHK: begin
        if (!pos_zero) phase_next = check_ok ? PH_DATA : PH_SYNC1;
      end
      PH_DATA: begin
        if (!in_payload && !at_check_low) phase_next = PH_SYNC1;
      end
      default:  phase_next = PH_SYNC1;
    endcase
  end

  // ---------------- datapath and result ----------------
  always_comb begin
    position_next        = position;
    type_reg_next        = type_reg;
    length_reg_next      = length_reg;
    sum_first_next       = sum_first;
    sum_second_next      = sum_second;
    held_check_byte_next = held_check_byte;
    sync_errors_next     = sync_errors;
    check_errors_next    = check_errors;
    good_frames_next     = good_frames;
    pv                   = 1'b0;
    pb                   = '0;
    poff                 = '0;
    ev                   = EV_NONE;
    case (phase)
      PH_SYNC1: begin
        position_next = '0;
        if (!sync1_ok) begin
          sync_errors_next = sync_errors + 1'b1;
          ev               = EV_SYNC;
        end
      end
      PH_SYNC2: begin
        if (!sync2_ok) begin
          sync_errors_next = sync_errors + 1'b1;
          ev               = EV_SYNC;
        end
      end
      PH_TYPE: begin
        // The header sums restart with the type byte.
        type_reg_next   = s1_byte;
        sum_first_next  = s1_byte;
        sum_second_next = s1_byte;
        position_next   = '0;
      end
      PH_LEN: begin
        sum_first_next  = sf_add;
        sum_second_next = ss_add;
        if (pos_zero) begin
          held_check_byte_next = s1_byte;
          position_next        = POS_W'(1);
        end else begin
          length_reg_next = {held_check_byte, s1_byte};
          position_next   = '0;
        end
      end
      PH_HCHK: begin
        if (pos_zero) begin
          held_check_byte_next = s1_byte;
          position_next        = POS_W'(1);
        end else begin
          position_next = '0;
          if (check_ok) begin
            sum_first_next  = '0;
            sum_second_next = '0;
          end else begin
            check_errors_next = check_errors + 1'b1;
            ev                = EV_HDR_BAD;
          end
        end
      end
      PH_DATA: begin
        if (in_payload) begin
          pv              = 1'b1;
          pb              = s1_byte;
          poff            = position[WORD_W-1:0];
          sum_first_next  = sf_add;
          sum_second_next = ss_add;
          position_next   = position + 1'b1;
        end else if (at_check_low) begin
          held_check_byte_next = s1_byte;
          position_next        = position + 1'b1;
        end else begin
          if (check_ok) begin
            good_frames_next = good_frames + 1'b1;
            ev               = EV_GOOD;
          end else begin
            check_errors_next = check_errors + 1'b1;
            ev                = EV_PAY_BAD;
          end
          position_next = '0;
        end
      end
      default: position_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC1;
      position        <= '0;
      type_reg        <= '0;
      length_reg      <= '0;
      sum_first       <= '0;
      sum_second      <= '0;
      held_check_byte <= '0;
      sync_errors     <= '0;
      check_errors    <= '0;
      good_frames     <= '0;
    end else if (s1_fire) begin
      phase           <= phase_next;
      position        <= position_next;
      type_reg        <= type_reg_next;
      length_reg      <= length_reg_next;
      sum_first       <= sum_first_next;
      sum_second      <= sum_second_next;
      held_check_byte <= held_check_byte_next;
      sync_errors     <= sync_errors_next;
      check_errors    <= check_errors_next;
      good_frames     <= good_frames_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_ch.payload_valid        <= pv;
      out_ch.payload_byte         <= pb;
      out_ch.payload_offset       <= poff;
      out_ch.frame_type           <= type_reg_next;
      out_ch.frame_length         <= length_reg_next;
      out_ch.event_code           <= ev;
      out_ch.sync_error_count     <= WORD_W'(sync_errors_next);
      out_ch.checksum_error_count <= WORD_W'(check_errors_next);
      out_ch.good_frame_count     <= WORD_W'(good_frames_next);
      out_ch.parser_phase         <= phase_next;
    end
  end

  // ---------------- assertions ----------------
  a_payload_no_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.payload_valid |->
      out_ch.event_code == EV_NONE && out_ch.parser_phase == PH_DATA)
    else $error("payload byte reported with an event or outside the data phase");

  a_frame_end_hunts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_ch.event_code == EV_GOOD || out_ch.event_code == EV_PAY_BAD ||
                  out_ch.event_code == EV_HDR_BAD) |-> out_ch.parser_phase == PH_SYNC1)
    else $error("frame end or header failure did not return the parser to hunting");

  a_sync_count: assert property (@(posedge clk) disable iff (rst)
    s1_fire && ev == EV_SYNC |=> sync_errors == $past(sync_errors) + 1'b1)
    else $error("sync error not counted");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> $stable(phase) && $stable(position))
    else $error("parser state moved while the result was stalled");

endmodule
`default_nettype wire

// File: sim/sync_frame_deframer_fletcher_unit_tb.sv
// Self-checking testbench for the byte-serial frame deframer with Fletcher checks.
`default_nettype none
module sync_frame_deframer_fletcher_unit_tb;
  import sfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef enum int {FR_GOOD, FR_BAD_SYNC, FR_BAD_HDR, FR_BAD_PAYLOAD, FR_CUT} frame_kind_t;

  typedef struct packed {
    logic              pay_valid;
    logic [BYTE_W-1:0] pay_byte;
    logic [WORD_W-1:0] pay_offset;
    logic [BYTE_W-1:0] ftype;
    logic [WORD_W-1:0] flen;
    event_t            evt;
    logic [WORD_W-1:0] sync_errs;
    logic [WORD_W-1:0] chk_errs;
    logic [WORD_W-1:0] good_cnt;
    phase_t            phase;
  } parse_result_t;

  logic clk;
  logic rst = 1'b1;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic              src_valid = 1'b0;
  logic [BYTE_W-1:0] src_byte = '0;
  logic              sink_ready = 1'b0;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  assign in_ch.valid   = src_valid;
  assign in_ch.rx_byte = src_byte;
  assign out_ch.ready  = sink_ready;

  sync_frame_deframer_fletcher_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bytes waiting to be sent and parser results still owed by the block.
  logic [BYTE_W-1:0] rx_bytes[$];
  parse_result_t     expected_results[$];
  int                fail_count = 0;
  int                quiet_cycles = 0;
  int                tx_gap = 0;
  int                tx_steady = 0;
  int                rx_stall = 0;
  int                rx_steady = 0;

  // Parser state mirrored by the checker.
  logic [BYTE_W-1:0]        cfg_sync_first = SYNC_FIRST_RESET;
  logic [BYTE_W-1:0]        cfg_sync_second = SYNC_SECOND_RESET;
  phase_t                   p_phase = PH_SYNC1;
  logic [POS_W-1:0]         p_pos = '0;
  logic [BYTE_W-1:0]        p_type = '0;
  logic [WORD_W-1:0]        p_len = '0;
  logic [BYTE_W-1:0]        p_sum1 = '0;
  logic [BYTE_W-1:0]        p_sum2 = '0;
  logic [BYTE_W-1:0]        p_held = '0;
  logic [COUNTER_WIDTH-1:0] p_sync_errs = '0;
  logic [COUNTER_WIDTH-1:0] p_chk_errs = '0;
  logic [COUNTER_WIDTH-1:0] p_good = '0;

  function automatic parse_result_t parse_byte(input logic [BYTE_W-1:0] b);
    parse_result_t r;
    r.pay_valid  = 1'b0;
    r.pay_byte   = '0;
    r.pay_offset = '0;
    r.evt        = EV_NONE;
    case (p_phase)
      PH_SYNC1: begin
        p_pos = '0;
        if (b == cfg_sync_first) begin
          p_phase = PH_SYNC2;
        end else begin
          p_sync_errs = p_sync_errs + 1'b1;
          r.evt = EV_SYNC;
        end
      end
      PH_SYNC2: begin
        // A wrong second sync byte is dropped, not retried as a first one.
        if (b == cfg_sync_second) begin
          p_phase = PH_TYPE;
        end else begin
          p_phase = PH_SYNC1;
          p_sync_errs = p_sync_errs + 1'b1;
          r.evt = EV_SYNC;
        end
      end
      PH_TYPE: begin
        p_type  = b;
        p_sum1  = b;
        p_sum2  = b;
        p_pos   = '0;
        p_phase = PH_LEN;
      end
      PH_LEN: begin
        p_sum1 = p_sum1 + b;
        p_sum2 = p_sum2 + p_sum1;
        if (p_pos == '0) begin
          p_held = b;
          p_pos  = POS_W'(1);
        end else begin
          p_len   = {p_held, b};
          p_pos   = '0;
          p_phase = PH_HCHK;
        end
      end
      PH_HCHK: begin
        if (p_pos == '0) begin
          p_held = b;
          p_pos  = POS_W'(1);
        end else begin
          p_pos = '0;
          if (p_held == p_sum1 && b == p_sum2) begin
            p_sum1  = '0;
            p_sum2  = '0;
            p_phase = PH_DATA;
          end else begin
            p_chk_errs = p_chk_errs + 1'b1;
            r.evt   = EV_HDR_BAD;
            p_phase = PH_SYNC1;
          end
        end
      end
      PH_DATA: begin
        if (p_pos < {1'b0, p_len}) begin
          r.pay_valid  = 1'b1;
          r.pay_byte   = b;
          r.pay_offset = p_pos[WORD_W-1:0];
          p_sum1 = p_sum1 + b;
          p_sum2 = p_sum2 + p_sum1;
          p_pos  = p_pos + 1'b1;
        end else if (p_pos == {1'b0, p_len}) begin
          p_held = b;
          p_pos  = p_pos + 1'b1;
        end else begin
          if (p_held == p_sum1 && b == p_sum2) begin
            p_good = p_good + 1'b1;
            r.evt  = EV_GOOD;
          end else begin
            p_chk_errs = p_chk_errs + 1'b1;
            r.evt = EV_PAY_BAD;
          end
          p_pos   = '0;
          p_phase = PH_SYNC1;
        end
      end
      default: begin
        p_phase = PH_SYNC1;
        p_pos   = '0;
      end
    endcase
    r.ftype     = p_type;
    r.flen      = p_len;
    r.sync_errs = p_sync_errs[WORD_W-1:0];
    r.chk_errs  = p_chk_errs[WORD_W-1:0];
    r.good_cnt  = p_good[WORD_W-1:0];
    r.phase     = p_phase;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int pick_gap(inout int steady);
    int r;
    if (steady > 0) begin
      steady = steady - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      steady = $urandom_range(30, 150);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic string fmt_result(input parse_result_t r);
    return $sformatf("pv=%0d pb=%02h off=%0d type=%02h len=%0d ev=%0d se=%0d ce=%0d gf=%0d ph=%0d",
                     r.pay_valid, r.pay_byte, r.pay_offset, r.ftype, r.flen, r.evt,
                     r.sync_errs, r.chk_errs, r.good_cnt, r.phase);
  endfunction

  task automatic note_failure(input string msg);
    fail_count = fail_count + 1;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Byte driver: one request per item, with random gaps between requests.
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (src_valid && in_ch.ready) expected_results.push_back(parse_byte(src_byte));
      if (!src_valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
          src_valid <= 1'b0;
        end else if (rx_bytes.size() != 0) begin
          src_valid <= 1'b1;
          src_byte  <= rx_bytes.pop_front();
          tx_gap = pick_gap(tx_steady);
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin : result_monitor
    parse_result_t got;
    parse_result_t want;
    if (rst) begin
      sink_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_ch.valid && sink_ready) begin
        got.pay_valid  = out_ch.payload_valid;
        got.pay_byte   = out_ch.payload_byte;
        got.pay_offset = out_ch.payload_offset;
        got.ftype      = out_ch.frame_type;
        got.flen       = out_ch.frame_length;
        got.evt        = event_t'(out_ch.event_code);
        got.sync_errs  = out_ch.sync_error_count;
        got.chk_errs   = out_ch.checksum_error_count;
        got.good_cnt   = out_ch.good_frame_count;
        got.phase      = phase_t'(out_ch.parser_phase);
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: %s", fmt_result(got)));
        end else begin
          want = expected_results.pop_front();
          if (got !== want)
            note_failure($sformatf("mismatch\n  expected %s\n  actual   %s",
                                   fmt_result(want), fmt_result(got)));
        end
        rx_stall = pick_gap(rx_steady);
      end
      if (rx_stall > 0) begin
        rx_stall = rx_stall - 1;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (src_valid && in_ch.ready) || (out_ch.valid && sink_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("sync_frame_deframer_fletcher_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_sync_reg(input logic idx, input logic [BYTE_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    // Upper bits carry junk; only the low byte is kept.
    pwdata  <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SYNC_FIRST) cfg_sync_first = value;
    else cfg_sync_second = value;
  endtask

  task automatic queue_frame(input frame_kind_t kind, input logic [BYTE_W-1:0] ftype,
                             input logic [WORD_W-1:0] flen);
    logic [BYTE_W-1:0] fr[$];
    logic [BYTE_W-1:0] c1;
    logic [BYTE_W-1:0] c2;
    logic [BYTE_W-1:0] d;
    int cut;
    c1 = '0;
    c2 = '0;
    fr.push_back(cfg_sync_first);
    if (kind == FR_BAD_SYNC) begin
      fr.push_back(cfg_sync_second ^ 8'($urandom_range(1, 255)));
    end else begin
      fr.push_back(cfg_sync_second);
      fr.push_back(ftype);
      fr.push_back(flen[15:8]);
      fr.push_back(flen[7:0]);
      for (int i = 2; i < 5; i++) begin
        c1 += fr[i];
        c2 += c1;
      end
      if (kind == FR_BAD_HDR) begin
        if ($urandom_range(0, 1) == 1) c1 ^= 8'($urandom_range(1, 255));
        else c2 ^= 8'($urandom_range(1, 255));
      end
      fr.push_back(c1);
      fr.push_back(c2);
      if (kind != FR_BAD_HDR) begin
        c1 = '0;
        c2 = '0;
        for (int i = 0; i < int'(flen); i++) begin
          d = 8'($urandom_range(0, 255));
          fr.push_back(d);
          c1 += d;
          c2 += c1;
        end
        if (kind == FR_BAD_PAYLOAD) begin
          if ($urandom_range(0, 1) == 1) c1 ^= 8'($urandom_range(1, 255));
          else c2 ^= 8'($urandom_range(1, 255));
        end
        fr.push_back(c1);
        fr.push_back(c2);
      end
    end
    cut = fr.size();
    // A truncated frame leaves the parser mid-frame; what follows gets absorbed.
    if (kind == FR_CUT) cut = $urandom_range(1, fr.size() - 1);
    for (int i = 0; i < cut; i++) rx_bytes.push_back(fr[i]);
  endtask

  task automatic queue_random(input int budget);
    int start;
    int r;
    logic [WORD_W-1:0] flen;
    frame_kind_t kind;
    start = rx_bytes.size();
    while (rx_bytes.size() - start < budget) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) flen = 16'($urandom_range(25, 200));
      else flen = 16'($urandom_range(0, 24));
      if (r < 85) begin
        if (r < 60) kind = FR_GOOD;
        else if (r < 67) kind = FR_BAD_SYNC;
        else if (r < 74) kind = FR_BAD_HDR;
        else if (r < 80) kind = FR_BAD_PAYLOAD;
        else kind = FR_CUT;
        // The header is rejected anyway, so its length may take any value.
        if (kind == FR_BAD_HDR) flen = 16'($urandom);
        queue_frame(kind, 8'($urandom_range(0, 255)), flen);
      end else begin
        repeat ($urandom_range(1, 4))
          rx_bytes.push_back(($urandom_range(0, 3) == 0) ? cfg_sync_first
                                                        : 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Holds off until every request has been answered.
  task automatic wait_drained();
    @(negedge clk);
    while (rx_bytes.size() != 0 || src_valid || expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic run_setting(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
                             input int budget);
    wait_drained();
    repeat (4) @(posedge clk);
    write_sync_reg(REG_SYNC_FIRST, first);
    write_sync_reg(REG_SYNC_SECOND, second);
    @(negedge clk);
    queue_random(budget);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: stray bytes at both extremes, a repeated first sync byte,
    // an empty frame and a one-byte frame with a broken payload check.
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    rx_bytes.push_back(cfg_sync_first);
    rx_bytes.push_back(cfg_sync_first);
    queue_frame(FR_GOOD, 8'h00, 16'd0);
    queue_frame(FR_BAD_PAYLOAD, 8'hFF, 16'd1);
    queue_random(250);

    run_setting(8'h00, 8'hFF, 250);
    run_setting(8'hFF, 8'h00, 250);
    run_setting(8'h5A, 8'h5A, 250);
    run_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 250);
    run_setting(SYNC_FIRST_RESET, SYNC_SECOND_RESET, 60);
    // A payload long enough that its offsets carry into the upper byte.
    queue_frame(FR_GOOD, 8'($urandom_range(0, 255)), 16'h0101);
    queue_random(60);

    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));
    if (fail_count == 0) begin
      $display("sync_frame_deframer_fletcher_unit verification clean");
    end else begin
      $display("sync_frame_deframer_fletcher_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
